FILE: rtl/core/okfl_pkg.sv
// shared types and codes for the ordered key free list
package okfl_pkg;

  // operation codes of a request word
  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RESERVE = 3'd1,
    OP_EXISTS  = 3'd2,
    OP_RESTORE = 3'd3,
    OP_REBUILD = 3'd4
  } op_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic CFG_RANGE_FIRST = 1'b0;
  localparam logic CFG_RANGE_LAST  = 1'b1;

  localparam int FIELD_KEY_W = 16;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic capture;    // register the compare result against the request key
    logic shift_all;  // every cell takes its right neighbor (pop oldest)
    logic shift_gap;  // cells at or after the first match take their neighbor
    logic restore;    // the cell at the tail position loads the key
    logic rebuild;    // every cell loads first plus its own position
  } cell_ctl_t;

endpackage

FILE: rtl/core/okfl_req_if.sv
// request channel: operation and key
interface okfl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

FILE: rtl/core/okfl_rsp_if.sv
// response channel: allocated key, status and key count
interface okfl_rsp_if #(
  parameter int COUNT_W = 9
);
  logic               valid;
  logic               ready;
  logic [15:0]        key_out;
  logic [1:0]         status;
  logic [COUNT_W-1:0] free_count;

  modport source (output valid, output key_out, output status, output free_count, input ready);
  modport sink   (input valid, input key_out, input status, input free_count, output ready);
endinterface

FILE: rtl/core/okfl_prefix_or.sv
// log-depth running or across the match bits of the row
module okfl_prefix_or #(
  parameter int N = 256
) (
  input  logic [N-1:0] a,
  output logic [N-1:0] y
);
  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = a;

  // each level folds in the partner 2**l places toward the front
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_fold
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign y = lvl[LEVELS];
endmodule

FILE: rtl/core/okfl_cell.sv
// one list position: holds a key, compares it, and shifts or loads
module okfl_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CW        = 9,
  parameter int INDEX     = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  okfl_pkg::cell_ctl_t      ctl,
  input  logic [CW-1:0]            count,
  input  logic [KEY_WIDTH-1:0]     key,
  input  logic [15:0]              range_first,
  input  logic [KEY_WIDTH-1:0]     next_key,
  input  logic                     gap_before,
  output logic [KEY_WIDTH-1:0]     cell_key,
  output logic                     match
);
  import okfl_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic                 occupied;
  logic [31:0]          range_sum;
  logic [KEY_WIDTH-1:0] range_key;

  assign occupied  = IDX < count;
  assign range_sum = 32'(range_first) + 32'(INDEX);
  assign range_key = range_sum[KEY_WIDTH-1:0];

  // compare result, taken when the request word is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.capture) begin
      match <= occupied && (cell_key == key);
    end
  end

  // key storage: shift from the right neighbor or load
  always_ff @(posedge clk) begin
    priority if (ctl.shift_all || (ctl.shift_gap && gap_before)) begin
      cell_key <= next_key;
    end else if (ctl.restore && (IDX == count)) begin
      cell_key <= key;
    end else if (ctl.rebuild) begin
      cell_key <= range_key;
    end
  end
endmodule

FILE: rtl/core/ordered_key_free_list.sv
// top level of the ordered key free list
//
//  channel | dir | handshake           | payload
//  req     | in  | valid/ready         | operation, key
//  rsp     | out | valid/ready         | key_out, status, free_count
//  cfg     | in  | cfg_we, no back-off | cfg_index, cfg_data
//
// each request word is first compared against the key in every cell of the
// row, then the row is updated through the running-or of the match bits.
// a new request is taken once the previous one has left the row, even while
// its response word waits in the output register; a held response stalls
// the update step. reset is synchronous and empties the list at once.
module ordered_key_free_list #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  okfl_req_if.sink                   req,
  okfl_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_data
);
  import okfl_pkg::*;

  localparam int            CW      = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t               state, state_next;
  op_t                  op;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] req_key;
  logic [31:0]          req_key_wide;
  logic [CW-1:0]        count, count_next;
  logic [15:0]          range_first, range_last;

  logic                 rsp_valid;
  logic [15:0]          rsp_key;
  status_t              rsp_status;
  logic [CW-1:0]        rsp_count;
  logic [31:0]          rsp_count_wide;

  logic                 capture, fire;
  cell_ctl_t            ctl;
  logic [KEY_WIDTH-1:0] cell_keys [DEPTH];
  logic [DEPTH-1:0]     match, gap;
  logic                 any_match;

  logic [16:0]          span;
  logic [31:0]          span_wide;
  logic [31:0]          head_wide;
  logic [15:0]          res_key;
  status_t              res_status;

  // key narrowed or widened to the cell width
  assign req_key_wide = 32'(req.key);
  assign req_key      = req_key_wide[KEY_WIDTH-1:0];

  assign capture = req.valid && req.ready;
  assign fire    = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_first <= 16'd1;
      range_last  <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_FIRST: range_first <= cfg_data;
        CFG_RANGE_LAST:  range_last  <= cfg_data;
        default:         range_first <= range_first;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (capture) state_next = S_EXEC;
      S_EXEC: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // request word held for the update step
  always_ff @(posedge clk) begin
    if (capture) begin
      op    <= op_t'(req.operation);
      key_q <= req_key;
    end
  end

  // cell controls
  always_comb begin
    ctl           = '0;
    ctl.capture   = capture;
    ctl.shift_all = fire && (op == OP_ALLOC) && (count != '0);
    ctl.shift_gap = fire && (op == OP_RESERVE);
    ctl.restore   = fire && (op == OP_RESTORE) && (count != DEPTH_C);
    ctl.rebuild   = fire && (op == OP_REBUILD);
  end

  // row of cells, each fed by its right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    okfl_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CW        (CW),
      .INDEX     (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .count       (count),
      .key         (capture ? req_key : key_q),
      .range_first (range_first),
      .next_key    (cell_keys[(i + 1 < DEPTH) ? i + 1 : i]),
      .gap_before  (gap[i]),
      .cell_key    (cell_keys[i]),
      .match       (match[i])
    );
  end

  okfl_prefix_or #(.N(DEPTH)) u_prefix (
    .a (match),
    .y (gap)
  );

  assign any_match = gap[DEPTH-1];
  assign head_wide = 32'(cell_keys[0]);
  assign span      = {1'b0, range_last} - {1'b0, range_first} + 17'd1;
  assign span_wide = 32'(span);

  // result and new count
  always_comb begin
    res_key    = '0;
    res_status = ST_OK;
    count_next = count;
    unique case (op)
      OP_ALLOC: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_key    = head_wide[15:0];
          count_next = count - CW'(1);
        end
      end
      OP_RESERVE: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else if (any_match) begin
          count_next = count - CW'(1);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_EXISTS: begin
        if (!any_match) res_status = ST_NOT_FOUND;
      end
      OP_RESTORE: begin
        if (count == DEPTH_C) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_REBUILD: begin
        if (range_last < range_first) begin
          count_next = '0;
        end else if (span_wide > 32'(DEPTH)) begin
          count_next = DEPTH_C;
          res_status = ST_FULL;
        end else begin
          count_next = span_wide[CW-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // key count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_key    <= res_key;
      rsp_status <= res_status;
      rsp_count  <= count_next;
    end
  end

  // count reported in the 9-bit field of the response word
  assign rsp_count_wide = 32'(rsp_count);

  assign rsp.valid      = rsp_valid;
  assign rsp.key_out    = rsp_key;
  assign rsp.status     = rsp_status;
  assign rsp.free_count = rsp_count_wide[8:0];

  // count never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("key count beyond depth");

  // an accepted request word moves to the update step
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    capture |=> (state == S_EXEC))
    else $error("accepted word not in update step");

  // an empty status always reports an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_count == '0))
    else $error("empty status with keys held");

  // only a successful pop returns a key
  a_key_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_key == '0))
    else $error("key returned with failing status");

  // the held response word is not replaced while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |-> !fire)
    else $error("response overwritten while pending");
endmodule
